FILE: design/dual_key_lookup_table_macros.svh
// Assertion helpers for the dual-key lookup table.
`ifndef DUAL_KEY_LOOKUP_TABLE_MACROS_SVH
`define DUAL_KEY_LOOKUP_TABLE_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define DKL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that must hold on every result beat.
`define DKL_ASSERT_RES(lbl, cond, msg) \
  `DKL_ASSERT(lbl, valid_o |-> (cond), msg)

`endif

FILE: design/dkl_pkg.sv
`timescale 1ns / 1ps

package dkl_pkg;

  localparam int DEPTH           = 16;
  localparam int FIRST_KEY_BITS  = 32;
  localparam int SECOND_KEY_BITS = 8;
  localparam int VALUE_BITS      = 32;
  localparam int IDX_BITS        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS        = $clog2(DEPTH + 1);
  localparam int OP_BITS         = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT        = 2'd0,
    OP_LOOKUP_FIRST  = 2'd1,
    OP_LOOKUP_SECOND = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_BITS-1:0]         op;
    logic [FIRST_KEY_BITS-1:0]  first_key;
    logic [SECOND_KEY_BITS-1:0] second_key;
    logic [VALUE_BITS-1:0]      new_value;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic [CNT_BITS-1:0]   stored_count;
    logic                  rejected;
  } rsp_t;

endpackage

FILE: design/dkl_in_reg.sv
`timescale 1ns / 1ps

module dkl_in_reg import dkl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  req_t req_i,
  output logic valid_o,
  output req_t req_o
);

  logic valid_q;
  req_t req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  // hold the last beat when idle
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

FILE: design/dkl_table.sv
`timescale 1ns / 1ps

module dkl_table import dkl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic [VALUE_BITS-1:0]      vals_q [DEPTH];
  logic [FIRST_KEY_BITS-1:0]  k1_q   [DEPTH];
  logic [SECOND_KEY_BITS-1:0] k2_q   [DEPTH];
  logic [DEPTH-1:0]           b1_q, b1_d;
  logic [DEPTH-1:0]           b2_q, b2_d;
  logic [CNT_BITS-1:0]        count_q, count_d;

  logic [DEPTH-1:0]      match1, match2, sel;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  full, do_insert, is_lookup;
  logic [IDX_BITS-1:0]   wr_idx;

  // Bound keys are unique in each key space, so at most one entry hits.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match1[i] = b1_q[i] && (k1_q[i] == req_i.first_key);
      match2[i] = b2_q[i] && (k2_q[i] == req_i.second_key);
    end
  end

  assign full      = (count_q == CNT_BITS'(DEPTH));
  assign do_insert = valid_i && (req_i.op == OP_INSERT) && !full;
  assign wr_idx    = count_q[IDX_BITS-1:0];

  always_comb begin
    sel       = '0;
    is_lookup = 1'b0;
    case (op_e'(req_i.op))
      OP_LOOKUP_FIRST: begin
        sel       = match1;
        is_lookup = 1'b1;
      end
      OP_LOOKUP_SECOND: begin
        sel       = match2;
        is_lookup = 1'b1;
      end
      default: begin
        sel       = '0;
        is_lookup = 1'b0;
      end
    endcase
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        hit_value = hit_value | vals_q[i];
      end
    end
  end

  always_comb begin
    b1_d    = b1_q;
    b2_d    = b2_q;
    count_d = count_q;
    if (do_insert) begin
      // first binding of a key wins
      b1_d[wr_idx] = ~|match1;
      b2_d[wr_idx] = ~|match2;
      count_d      = count_q + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q    <= '0;
      b2_q    <= '0;
      count_q <= '0;
    end else begin
      b1_q    <= b1_d;
      b2_q    <= b2_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      vals_q[wr_idx] <= req_i.new_value;
      k1_q[wr_idx]   <= req_i.first_key;
      k2_q[wr_idx]   <= req_i.second_key;
    end
  end

  assign rsp_o.found        = is_lookup && |sel;
  assign rsp_o.read_value   = is_lookup ? hit_value : '0;
  assign rsp_o.stored_count = count_d;
  assign rsp_o.rejected     = (req_i.op == OP_INSERT) && full;

endmodule

FILE: design/dkl_out_reg.sv
`timescale 1ns / 1ps

module dkl_out_reg import dkl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rsp_t rsp_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  logic valid_q;
  rsp_t rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

FILE: design/dual_key_lookup_table.sv
`timescale 1ns / 1ps

// Dual-key lookup table: up to DEPTH values, each reachable by a first key
// or a second key. operation_i selects insert, lookup by first key or
// lookup by second key; an insert stores new_value_i in the next free slot
// and binds each key only if that key is not bound yet.
// Command channel: a beat is taken at a rising edge with start_i high and
// busy_o low. busy_o stays low, so a beat may be issued every cycle.
// Result channel: one beat per command, shown for exactly one cycle with
// valid_o high. valid_o rises once the command has passed the input
// register and the result register. Throughput is one item per cycle: an
// input register feeds a single pass of parallel key compare and table
// update, which loads the result register. Back-to-back commands see each
// other's inserts in order.
// An insert into a full table is dropped and flagged on rejected_o.
// Reset clears the entry count and all key bindings; no results are pending
// after reset. The receiver cannot stall; results must be taken when shown.
module dual_key_lookup_table import dkl_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [OP_BITS-1:0]         operation_i,
  input  logic [FIRST_KEY_BITS-1:0]  first_key_i,
  input  logic [SECOND_KEY_BITS-1:0] second_key_i,
  input  logic [VALUE_BITS-1:0]      new_value_i,
  output logic                       valid_o,
  output logic                       found_o,
  output logic [VALUE_BITS-1:0]      read_value_o,
  output logic [CNT_BITS-1:0]        stored_count_o,
  output logic                       rejected_o
);

  req_t req_in, req_s1;
  rsp_t rsp_s1, rsp_out;
  logic accept, valid_s1;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign req_in.op         = operation_i;
  assign req_in.first_key  = first_key_i;
  assign req_in.second_key = second_key_i;
  assign req_in.new_value  = new_value_i;

  dkl_in_reg u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_in),
    .valid_o  (valid_s1),
    .req_o    (req_s1)
  );

  dkl_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s1),
    .req_i   (req_s1),
    .rsp_o   (rsp_s1)
  );

  dkl_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_s1),
    .rsp_i   (rsp_s1),
    .valid_o (valid_o),
    .rsp_o   (rsp_out)
  );

  assign found_o        = rsp_out.found;
  assign read_value_o   = rsp_out.read_value;
  assign stored_count_o = rsp_out.stored_count;
  assign rejected_o     = rsp_out.rejected;

endmodule

FILE: design/dkl_checker.sv
`timescale 1ns / 1ps

`include "dual_key_lookup_table_macros.svh"

module dkl_checker import dkl_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic                       valid_o,
  input logic                       found_o,
  input logic [VALUE_BITS-1:0]      read_value_o,
  input logic [CNT_BITS-1:0]        stored_count_o,
  input logic                       rejected_o
);

  `DKL_ASSERT(a_beat_yields_result, (start_i && !busy_o) |-> ##2 valid_o, "result beat missing")
  `DKL_ASSERT(a_no_spurious_result, !(start_i && !busy_o) |-> ##2 !valid_o, "result beat without command")
  `DKL_ASSERT_RES(a_count_in_range, stored_count_o <= CNT_BITS'(DEPTH), "entry count above depth")
  `DKL_ASSERT_RES(a_reject_when_full, !rejected_o || (stored_count_o == CNT_BITS'(DEPTH) && !found_o), "reject without full table")
  `DKL_ASSERT_RES(a_miss_reads_zero, found_o || (read_value_o == '0), "nonzero value on miss")

endmodule

bind dual_key_lookup_table dkl_checker u_dkl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .valid_o        (valid_o),
  .found_o        (found_o),
  .read_value_o   (read_value_o),
  .stored_count_o (stored_count_o),
  .rejected_o     (rejected_o)
);
